[src/assert_macros.svh]
// Assertion helpers used by the checker file.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset
`define CTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define CTS_ASSERT_IMPL(lbl, a, c, msg) `CTS_ASSERT(lbl, (a) |-> (c), msg)

// Check that a condition implies a consequence in the next cycle
`define CTS_ASSERT_NEXT(lbl, a, c, msg) `CTS_ASSERT(lbl, (a) |=> (c), msg)

`endif

[src/cts_pkg.sv]
`default_nettype none
package cts_pkg;

	// Configuration port index width and register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP     = 3'd4;

	// Reset value of the cycle interval register
	localparam longint unsigned INTERVAL_RESET = 64'd1000000;

	// Mode bits and state events decoded from a configuration write
	typedef struct packed {
		logic sensor_enable;
		logic loop_mode;
		logic arm;
		logic disarm;
		logic halt;
	} cfg_ctl_t;

	// Flag fields of one result word
	typedef struct packed {
		logic active;
		logic active_changed;
		logic cycle_started;
		logic fraction_valid;
	} res_flags_t;

endpackage
`default_nettype wire

[src/cyclic_time_sensor.sv]
`default_nettype none
// Cyclic time sensor.
// Input channel (in_valid/in_ready, now): one word per simulation tick with
// the current absolute time. Output channel (out_valid/out_ready): at most
// one result word per tick with the echoed time, running flag, start of the
// current cycle, completed fraction (unsigned 1.FRACTION_BITS) and strobes.
// Idle ticks give no word unless they start the sensor or follow a disable.
// Configuration port (cfg_we, cfg_index, cfg_data): single-cycle writes of
// the interval, enable, loop, start and stop registers; interval and start
// writes are made while idle; the block ignores them while the sensor runs.
// Division: one shared restoring division step runs first over the elapsed
// time for the remainder (only when a cycle boundary was passed) and then
// over the fraction; a tick that lands exactly on a boundary skips the
// fraction pass, and a tick that gives no word or the word after a disable
// skips the division.
// in_ready is high only while the sequencer is idle.
// Results leave through an output register; the next tick is taken while a
// result waits there, and a stalled receiver holds the word and its valid.
// Reset: registers go to their reset values, the sensor is idle and armed.
module cyclic_time_sensor #(
	parameter int TIME_BITS     = 48,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [TIME_BITS-1:0]          now,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [TIME_BITS-1:0]               time_now,
	output logic                               active,
	output logic                               active_changed,
	output logic [TIME_BITS-1:0]               cycle_begin,
	output logic                               cycle_started,
	output logic [FRACTION_BITS:0]             fraction,
	output logic                               fraction_valid,
	input  wire logic                          cfg_we,
	input  wire logic [cts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TIME_BITS-1:0]          cfg_data
);
	import cts_pkg::*;

	logic [TIME_BITS-1:0]   interval;
	logic [TIME_BITS-1:0]   start_time;
	logic [TIME_BITS-1:0]   stop_time;
	cfg_ctl_t               ctl;
	logic                   running;
	logic                   res_valid;
	logic                   res_ready;
	logic [TIME_BITS-1:0]   res_time;
	logic [TIME_BITS-1:0]   res_begin;
	logic [FRACTION_BITS:0] res_fraction;
	res_flags_t             res_flags;

	logic                   out_valid_q;
	logic [TIME_BITS-1:0]   time_q;
	logic [TIME_BITS-1:0]   begin_q;
	logic [FRACTION_BITS:0] fraction_q;
	res_flags_t             flags_q;

	cts_cfg #(.TIME_BITS(TIME_BITS)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.running    (running),
		.interval   (interval),
		.start_time (start_time),
		.stop_time  (stop_time),
		.ctl        (ctl)
	);

	cts_core #(
		.TIME_BITS     (TIME_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now          (now),
		.interval     (interval),
		.start_time   (start_time),
		.stop_time    (stop_time),
		.ctl          (ctl),
		.running      (running),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_time     (res_time),
		.res_begin    (res_begin),
		.res_fraction (res_fraction),
		.res_flags    (res_flags)
	);

	// Load the output register when it is empty or being drained
	assign res_ready = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			time_q     <= res_time;
			begin_q    <= res_begin;
			fraction_q <= res_fraction;
			flags_q    <= res_flags;
		end
	end

	assign out_valid      = out_valid_q;
	assign time_now       = time_q;
	assign cycle_begin    = begin_q;
	assign fraction       = fraction_q;
	assign active         = flags_q.active;
	assign active_changed = flags_q.active_changed;
	assign cycle_started  = flags_q.cycle_started;
	assign fraction_valid = flags_q.fraction_valid;
endmodule
`default_nettype wire

[src/cts_divstep.sv]
`default_nettype none
// One restoring division step: shift in a bit, compare with the divisor,
// subtract when it fits. The partial remainder stays below the divisor.
module cts_divstep #(
	parameter int W = 48
) (
	input  wire logic [W-1:0] r,
	input  wire logic         in_bit,
	input  wire logic [W-1:0] d,
	output logic [W-1:0]      r_next,
	output logic              q_bit
);
	logic [W:0]   shifted;
	logic [W+1:0] sub;

	// Shift, trial subtract, keep or restore
	always_comb begin
		shifted = {r, in_bit};
		sub     = {1'b0, shifted} - {2'b00, d};
		q_bit   = ~sub[W+1];
		r_next  = q_bit ? sub[W-1:0] : shifted[W-1:0];
	end
endmodule
`default_nettype wire

[src/cts_cfg.sv]
`default_nettype none
// Configuration registers and decode of writes into sensor state events.
module cts_cfg #(
	parameter int TIME_BITS = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TIME_BITS-1:0]          cfg_data,
	input  wire logic                          running,
	output logic [TIME_BITS-1:0]               interval,
	output logic [TIME_BITS-1:0]               start_time,
	output logic [TIME_BITS-1:0]               stop_time,
	output cts_pkg::cfg_ctl_t                  ctl
);
	import cts_pkg::*;

	logic [TIME_BITS-1:0] interval_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] stop_q;
	logic                 enable_q;
	logic                 loop_q;

	// Write registers; interval and start hold while running
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= TIME_BITS'(INTERVAL_RESET);
			start_q    <= '0;
			stop_q     <= '0;
			enable_q   <= 1'b1;
			loop_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL: begin
					if (!running) begin
						interval_q <= (cfg_data == '0) ? TIME_BITS'(1) : cfg_data;
					end
				end
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_LOOP:   loop_q   <= cfg_data[0];
				REG_START: begin
					if (!running) begin
						start_q <= cfg_data;
					end
				end
				REG_STOP:   stop_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode arm, disarm and halt events for the sequencer
	always_comb begin
		ctl               = '0;
		ctl.sensor_enable = enable_q;
		ctl.loop_mode     = loop_q;
		if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: begin
					ctl.disarm = ~cfg_data[0];
					ctl.halt   = ~cfg_data[0] & running;
					ctl.arm    = cfg_data[0] & ~running;
				end
				REG_LOOP:  ctl.arm = cfg_data[0] & ~running;
				REG_START: ctl.arm = ~running;
				default: ;
			endcase
		end
	end

	assign interval   = interval_q;
	assign start_time = start_q;
	assign stop_time  = stop_q;
endmodule
`default_nettype wire

[src/cts_core.sv]
`default_nettype none
// Sensor state and the sequencer that drives the shared division step:
// a remainder pass over the elapsed time, then the fraction bits.
module cts_core #(
	parameter int TIME_BITS     = 48,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [TIME_BITS-1:0]     now,
	input  wire logic [TIME_BITS-1:0]     interval,
	input  wire logic [TIME_BITS-1:0]     start_time,
	input  wire logic [TIME_BITS-1:0]     stop_time,
	input  wire cts_pkg::cfg_ctl_t        ctl,
	output logic                          running,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output logic [TIME_BITS-1:0]          res_time,
	output logic [TIME_BITS-1:0]          res_begin,
	output logic [FRACTION_BITS:0]        res_fraction,
	output cts_pkg::res_flags_t           res_flags
);
	import cts_pkg::*;

	localparam int CNT_W  = $clog2((TIME_BITS > FRACTION_BITS) ? TIME_BITS : FRACTION_BITS);
	localparam int FRAC_W = FRACTION_BITS + 1;
	localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_REM   = 3'd3;
	localparam logic [2:0] S_ADJ   = 3'd4;
	localparam logic [2:0] S_FRAC  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]           state_q;
	logic                 running_q;
	logic                 armed_q;
	logic                 pend_q;
	logic                 emit_pend_q;
	logic [TIME_BITS-1:0] cur_start_q;
	logic [FRAC_W-1:0]    last_frac_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] diff_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [FRAC_W-1:0]    frac_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 changed_q;
	logic                 new_cycle_q;
	logic                 stop_q;

	logic                 start_ok;
	logic                 stop_hit;
	logic [TIME_BITS-1:0] cs;
	logic [TIME_BITS-1:0] diff_next;
	logic [TIME_BITS-1:0] r_fix;
	logic                 step_in;
	logic [TIME_BITS-1:0] step_r;
	logic                 step_q;

	// Shared compare and subtract step
	assign step_in = (state_q == S_REM) ? diff_q[cnt_q] : 1'b0;

	cts_divstep #(.W(TIME_BITS)) u_step (
		.r      (rem_q),
		.in_bit (step_in),
		.d      (interval),
		.r_next (step_r),
		.q_bit  (step_q)
	);

	// Start, stop and elapsed time of the latched tick
	always_comb begin
		start_ok  = ~running_q & ctl.sensor_enable & armed_q & (now_q >= start_time);
		stop_hit  = (stop_time > start_time) & (now_q >= stop_time);
		cs        = running_q ? cur_start_q : start_time;
		diff_next = (now_q >= cs) ? (now_q - cs) : '0;
		r_fix     = (rem_q == '0) ? interval : rem_q;
	end

	// Sequencer and sensor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			armed_q     <= 1'b1;
			pend_q      <= 1'b0;
			emit_pend_q <= 1'b0;
			cur_start_q <= '0;
			last_frac_q <= '0;
		end else begin
			// Apply configuration events
			if (ctl.halt) begin
				running_q <= 1'b0;
				pend_q    <= 1'b1;
			end
			if (ctl.disarm) begin
				armed_q <= 1'b0;
			end else if (ctl.arm) begin
				armed_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					emit_pend_q <= pend_q;
					if (pend_q) begin
						pend_q  <= 1'b0;
						state_q <= S_DONE;
					end else if (running_q || start_ok) begin
						cur_start_q <= cs;
						state_q     <= S_CHECK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_CHECK: begin
					if (diff_q > interval) begin
						state_q <= S_REM;
					end else if (diff_q == interval) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FRAC;
					end
				end
				S_REM: begin
					if (cnt_q == '0) begin
						state_q <= S_ADJ;
					end
				end
				S_ADJ: begin
					cur_start_q <= now_q - r_fix;
					state_q     <= (rem_q == '0) ? S_DONE : S_FRAC;
				end
				S_FRAC: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						if (!emit_pend_q) begin
							last_frac_q <= frac_q;
							running_q   <= ~stop_q;
							if (stop_q) begin
								armed_q <= 1'b0;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the current tick
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				now_q <= now;
			end
			S_EVAL: begin
				changed_q   <= start_ok;
				new_cycle_q <= start_ok;
				stop_q      <= stop_hit;
				diff_q      <= diff_next;
			end
			S_CHECK: begin
				frac_q <= '0;
				if (diff_q > interval) begin
					rem_q       <= '0;
					cnt_q       <= CNT_W'(TIME_BITS - 1);
					new_cycle_q <= 1'b1;
					if (!ctl.loop_mode) begin
						stop_q <= 1'b1;
					end
				end else if (diff_q == interval) begin
					frac_q <= FRAC_ONE;
				end else begin
					rem_q <= diff_q;
					cnt_q <= CNT_W'(FRACTION_BITS - 1);
				end
			end
			S_REM: begin
				rem_q <= step_r;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_ADJ: begin
				cnt_q  <= CNT_W'(FRACTION_BITS - 1);
				frac_q <= (rem_q == '0) ? FRAC_ONE : '0;
			end
			S_FRAC: begin
				rem_q  <= step_r;
				frac_q <= {frac_q[FRAC_W-2:0], step_q};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	// Result word
	always_comb begin
		res_flags.active         = ~emit_pend_q & ~stop_q;
		res_flags.active_changed = emit_pend_q | changed_q | stop_q;
		res_flags.cycle_started  = ~emit_pend_q & new_cycle_q;
		res_flags.fraction_valid = emit_pend_q | ~stop_q;
		if (emit_pend_q) begin
			res_fraction = last_frac_q;
		end else if (stop_q) begin
			res_fraction = '0;
		end else begin
			res_fraction = frac_q;
		end
	end

	assign res_time  = now_q;
	assign res_begin = cur_start_q;
	assign res_valid = (state_q == S_DONE);
	assign in_ready  = (state_q == S_IDLE);
	assign running   = running_q;
endmodule
`default_nettype wire

[src/cts_checker.sv]
`default_nettype none
`include "assert_macros.svh"
// Port-level checks of the cyclic time sensor.
module cts_port_checks #(
	parameter int TIME_BITS     = 48,
	parameter int FRACTION_BITS = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [TIME_BITS-1:0]          time_now,
	input wire logic                          active,
	input wire logic                          active_changed,
	input wire logic [TIME_BITS-1:0]          cycle_begin,
	input wire logic [FRACTION_BITS:0]        fraction,
	input wire logic                          fraction_valid
);
	localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	// A taken tick keeps the sequencer busy for at least the next cycle
	`CTS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after take")

	// The fraction never exceeds one
	`CTS_ASSERT_IMPL(a_frac_range, out_valid, fraction <= FRAC_ONE, "fraction above one")

	// A word without an activity change comes from a sensor that keeps running
	`CTS_ASSERT_IMPL(a_still_running, out_valid && !active_changed, active,
		"inactive word without change")

	// A stopping word carries no fraction and reports the stop
	`CTS_ASSERT_IMPL(a_stop_word, out_valid && !fraction_valid,
		fraction == '0 && !active && active_changed, "bad stopping word")

	// A stalled word holds
	`CTS_ASSERT_NEXT(a_hold, out_valid && !out_ready,
		out_valid && $stable(time_now) && $stable(cycle_begin), "stalled word changed")
endmodule

bind cyclic_time_sensor cts_port_checks #(
	.TIME_BITS     (TIME_BITS),
	.FRACTION_BITS (FRACTION_BITS)
) u_cts_checker (.*);
`default_nettype wire
